// ===== hdl/tpe_pkg.sv =====
// ----------------------------------------------------------------------------
// tpe_pkg
// Shared types, constants and bit-level helpers of the TMDS palette entry
// encoder.
// ----------------------------------------------------------------------------
package tpe_pkg;

  localparam int unsigned NumChan = 3;
  localparam int unsigned SymW    = 10;
  localparam int unsigned WordW   = 62;

  localparam logic [7:0]       FoldFrom   = 8'd252;
  localparam logic [7:0]       FoldTo     = 8'd48;
  localparam logic [WordW-1:0] SecondMask = 62'h0003_ffff_ffff_ffff;

  // register index, taken from paddr[2]
  localparam logic RegInvertPairs  = 1'b0;
  localparam logic RegRedHighOrder = 1'b1;

  typedef struct packed {
    logic invert_pairs;
    logic red_high_order;
  } cfg_t;

  // channel 2 red, 1 green, 0 blue
  typedef struct packed {
    logic [7:0]                 slot;
    logic [NumChan-1:0][7:0]    chan;
    logic [NumChan-1:0]         xnor_sel;
  } s1_t;

  typedef struct packed {
    logic [7:0]                     slot;
    logic [NumChan-1:0][SymW-1:0]   sym;
  } s2_t;

  typedef struct packed {
    logic [7:0]       slot;
    logic [WordW-1:0] first_word;
    logic [WordW-1:0] second_word;
  } s3_t;

  function automatic logic [3:0] ones_in_byte(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, v[i]};
    end
    return n;
  endfunction

  function automatic logic pick_xnor(input logic [7:0] d);
    logic [3:0] n;
    n = ones_in_byte(d);
    return (n > 4'd4) || ((n == 4'd4) && !d[0]);
  endfunction

  function automatic logic [SymW-1:0] tm_encode(input logic [7:0] d, input logic xn);
    logic [SymW-1:0] s;
    s    = '0;
    s[0] = d[0];
    for (int i = 1; i < 8; i++) begin
      s[i] = s[i-1] ^ d[i] ^ xn;
    end
    s[8] = !xn;
    s[9] = xn;
    return s;
  endfunction

  function automatic logic [1:0] make_pair(input logic b, input logic inv);
    return {!b, b} ^ {inv, inv};
  endfunction

endpackage

// ===== hdl/tpe_count.sv =====
// ----------------------------------------------------------------------------
// tpe_count
// First stage: fold the slot number and pick XOR or XNOR chaining per
// channel from its count of ones.
// ----------------------------------------------------------------------------
module tpe_count (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [7:0]        palette_index_i,
  input  logic [23:0]       colour_rgb_i,
  output logic              valid_o,
  input  logic              ready_i,
  output tpe_pkg::s1_t      data_o
);

  logic         valid_q;
  tpe_pkg::s1_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    data_d.chan = {colour_rgb_i[23:16], colour_rgb_i[15:8], colour_rgb_i[7:0]};
    if (palette_index_i >= tpe_pkg::FoldFrom) begin
      data_d.slot = tpe_pkg::FoldTo + {6'd0, palette_index_i[1:0]};
    end else begin
      data_d.slot = palette_index_i;
    end
    for (int c = 0; c < tpe_pkg::NumChan; c++) begin
      data_d.xnor_sel[c] = tpe_pkg::pick_xnor(data_d.chan[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== hdl/tpe_tmenc.sv =====
// ----------------------------------------------------------------------------
// tpe_tmenc
// Second stage: transition-minimizing chain of each channel byte into a
// 10-bit symbol.
// ----------------------------------------------------------------------------
module tpe_tmenc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  tpe_pkg::s1_t      data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output tpe_pkg::s2_t      data_o
);

  logic         valid_q;
  tpe_pkg::s2_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    data_d.slot = data_i.slot;
    for (int c = 0; c < tpe_pkg::NumChan; c++) begin
      data_d.sym[c] = tpe_pkg::tm_encode(data_i.chan[c], data_i.xnor_sel[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== hdl/tpe_pack.sv =====
// ----------------------------------------------------------------------------
// tpe_pack
// Third stage: serialize the symbols MSB first into differential pairs,
// pack 6-bit groups and form both words. Acts as the output register.
// ----------------------------------------------------------------------------
module tpe_pack (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tpe_pkg::cfg_t     cfg_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  tpe_pkg::s2_t      data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output tpe_pkg::s3_t      data_o
);

  logic         valid_q;
  tpe_pkg::s3_t data_d, data_q;
  logic [9:0][5:0] grp;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    logic [1:0] pr, pg, pb;
    for (int k = 0; k < 10; k++) begin
      pr = tpe_pkg::make_pair(data_i.sym[2][k], cfg_i.invert_pairs);
      pg = tpe_pkg::make_pair(data_i.sym[1][k], cfg_i.invert_pairs);
      pb = tpe_pkg::make_pair(data_i.sym[0][k], cfg_i.invert_pairs);
      if (cfg_i.red_high_order) begin
        grp[k] = {pr, pg, pb};
      end else begin
        grp[k] = {pb, pg, pr};
      end
    end
    data_d.slot        = data_i.slot;
    data_d.first_word  = {grp[9], grp[8], grp[7], grp[6], grp[5], 2'b00,
                          grp[4], grp[3], grp[2], grp[1], grp[0]};
    data_d.second_word = data_d.first_word ^ tpe_pkg::SecondMask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== hdl/tmds_palette_entry_encoder_top.sv =====
// ----------------------------------------------------------------------------
// tmds_palette_entry_encoder_top
// Palette entry encoder: index and RGB colour in, table slot and two
// serializer words out.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the output is not stalled, through the three
// register stages (ones count, TM chain, pair packing); the last
// stage is the output register, so a stalled output still lets the earlier
// stages fill. Registers: invert_pairs at byte 0, red_high_order at byte 4
// (paddr[2] selects); write them only while the pipeline is empty.
module tmds_palette_entry_encoder_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // palette_index[7:0], colour_rgb[31:8]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // table_slot[7:0], first_word[69:8],
                                       // second_word[131:70], zero[135:132]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  tpe_pkg::cfg_t cfg_q;
  tpe_pkg::s1_t  s1;
  tpe_pkg::s2_t  s2;
  tpe_pkg::s3_t  s3;
  logic          v1, r1, v2, r2;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        tpe_pkg::RegInvertPairs:  cfg_q.invert_pairs   <= pwdata[0];
        tpe_pkg::RegRedHighOrder: cfg_q.red_high_order <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tpe_pkg::RegInvertPairs:  prdata = {31'd0, cfg_q.invert_pairs};
      tpe_pkg::RegRedHighOrder: prdata = {31'd0, cfg_q.red_high_order};
      default:                  prdata = '0;
    endcase
  end

  tpe_count u_count (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (s_axis_tvalid),
    .ready_o         (s_axis_tready),
    .palette_index_i (s_axis_tdata[7:0]),
    .colour_rgb_i    (s_axis_tdata[31:8]),
    .valid_o         (v1),
    .ready_i         (r1),
    .data_o          (s1)
  );

  tpe_tmenc u_tmenc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .ready_o (r1),
    .data_i  (s1),
    .valid_o (v2),
    .ready_i (r2),
    .data_o  (s2)
  );

  tpe_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (v2),
    .ready_o (r2),
    .data_i  (s2),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (s3)
  );

  assign m_axis_tdata = {4'd0, s3.second_word, s3.first_word, s3.slot};

endmodule

// ===== hdl/tpe_checker.sv =====
// ----------------------------------------------------------------------------
// tpe_checker
// Port-level checks of the palette entry encoder, bound to the top level.
// ----------------------------------------------------------------------------
module tpe_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[131:70] == (m_axis_tdata[69:8] ^ tpe_pkg::SecondMask))
    else $error("second word does not match first word and mask");

  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:2] != 6'b111111)
    else $error("slot not folded");

  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[8] != m_axis_tdata[9])
                   && (m_axis_tdata[39:38] == 2'b00))
    else $error("bad differential pair or padding");

endmodule

bind tmds_palette_entry_encoder_top tpe_checker u_tpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/tmds_palette_entry_encoder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmds_palette_entry_encoder_top_tb
// Streams palette writes through the encoder and checks every entry against
// a bit-level predictor of slot folding, TM coding and pair serialization.
// Each setting of the pair inversion and channel order registers gets a
// phase of random beats; all but one phase add random stalls on both streams.
// ----------------------------------------------------------------------------
module tmds_palette_entry_encoder_top_tb;

  localparam int unsigned StallLimit = 2000;

  typedef struct packed {
    logic [23:0] rgb;
    logic [7:0]  idx;
  } colour_write_t;

  typedef struct packed {
    logic [7:0]                slot;
    logic [tpe_pkg::WordW-1:0] first_word;
    logic [tpe_pkg::WordW-1:0] second_word;
  } palette_entry_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;    // palette_index[7:0], colour_rgb[31:8]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;         // table_slot[7:0], first_word[69:8],
                                      // second_word[131:70], zero[135:132]
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  colour_write_t  pending_writes[$];
  palette_entry_t expected_entries[$];
  colour_write_t  next_write;
  palette_entry_t seen_entry;

  logic        pair_flip = 1'b0;
  logic        red_first = 1'b0;
  logic        stalls_on = 1'b1;
  logic        in_beat = 1'b0;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  tmds_palette_entry_encoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [9:0] tm_symbol(input logic [7:0] d);
    int         ones;
    logic       chain_xnor;
    logic [9:0] s;
    ones       = $countones(d);
    chain_xnor = (ones > 4) || (ones == 4 && !d[0]);
    s          = '0;
    s[0]       = d[0];
    for (int i = 1; i < 8; i++) begin
      s[i] = s[i-1] ^ d[i] ^ chain_xnor;
    end
    s[8] = !chain_xnor;
    s[9] = chain_xnor;
    return s;
  endfunction

  function automatic palette_entry_t encode_entry(input colour_write_t w);
    palette_entry_t            e;
    logic [9:0]                sr, sg, sb;
    logic [1:0]                pr, pg, pb;
    logic [tpe_pkg::WordW-1:0] word;
    int                        b;
    sr   = tm_symbol(w.rgb[23:16]);
    sg   = tm_symbol(w.rgb[15:8]);
    sb   = tm_symbol(w.rgb[7:0]);
    word = '0;
    for (int k = 0; k < 10; k++) begin
      b    = 9 - k;
      pr   = {!sr[b], sr[b]} ^ {2{pair_flip}};
      pg   = {!sg[b], sg[b]} ^ {2{pair_flip}};
      pb   = {!sb[b], sb[b]} ^ {2{pair_flip}};
      word = word << 6;
      if (k == 5) begin
        word = word << 2;
      end
      word[5:0] = red_first ? {pr, pg, pb} : {pb, pg, pr};
    end
    e.slot        = (w.idx >= tpe_pkg::FoldFrom) ?
                    tpe_pkg::FoldTo + (w.idx - tpe_pkg::FoldFrom) : w.idx;
    e.first_word  = word;
    e.second_word = word ^ tpe_pkg::SecondMask;
    return e;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(11))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'h0f;  // four ones, low bit set
      3:       return 8'h1e;  // four ones, low bit clear
      4:       return 8'h55;
      5:       return 8'haa;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  task automatic queue_write(input logic [7:0] idx, input logic [23:0] rgb);
    colour_write_t w;
    w.idx = idx;
    w.rgb = rgb;
    pending_writes.push_back(w);
  endtask

  task automatic queue_random(input int unsigned count);
    logic [7:0] idx;
    for (int unsigned n = 0; n < count; n++) begin
      idx = ($urandom_range(4) == 0) ? 8'($urandom_range(255, 244)) : 8'($urandom);
      queue_write(idx, {pick_byte(), pick_byte(), pick_byte()});
    end
  endtask

  task automatic write_reg(input logic sel, input logic val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {31'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == tpe_pkg::RegInvertPairs) begin
      pair_flip = val;
    end else begin
      red_first = val;
    end
  endtask

  task automatic set_mode(input logic flip, input logic red_hi);
    write_reg(tpe_pkg::RegInvertPairs, flip);
    write_reg(tpe_pkg::RegRedHighOrder, red_hi);
  endtask

  task automatic wait_drained();
    while (pending_writes.size() != 0 || s_axis_tvalid || expected_entries.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // driver and output backpressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || in_beat) begin
        if (pending_writes.size() != 0 && !(stalls_on && $urandom_range(99) < 16)) begin
          next_write = pending_writes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {next_write.rgb, next_write.idx};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !(stalls_on && $urandom_range(99) < 16);
    end
  end

  // monitor: check the output beat first, then predict the input beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_beat <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_entries.size() == 0) begin
          report_mismatch("unexpected beat, slot", 64'(m_axis_tdata[7:0]), '0);
        end else begin
          seen_entry = expected_entries.pop_front();
          if (m_axis_tdata[7:0] != seen_entry.slot)
            report_mismatch("table_slot", 64'(m_axis_tdata[7:0]), 64'(seen_entry.slot));
          if (m_axis_tdata[69:8] != seen_entry.first_word)
            report_mismatch("first_word", 64'(m_axis_tdata[69:8]),
                            64'(seen_entry.first_word));
          if (m_axis_tdata[131:70] != seen_entry.second_word)
            report_mismatch("second_word", 64'(m_axis_tdata[131:70]),
                            64'(seen_entry.second_word));
          if (m_axis_tdata[135:132] != 4'd0)
            report_mismatch("tdata padding", 64'(m_axis_tdata[135:132]), '0);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        next_write.idx = s_axis_tdata[7:0];
        next_write.rgb = s_axis_tdata[31:8];
        expected_entries.push_back(encode_entry(next_write));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel ||
        !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_mode(1'b0, 1'b0);
    queue_write(8'd0,   24'h000000);
    queue_write(8'd255, 24'hffffff);
    queue_write(8'd252, 24'h0f1e1f);
    queue_write(8'd253, 24'h1e0f07);
    queue_write(8'd254, 24'h55aa80);
    queue_write(8'd251, 24'h01ff00);
    queue_write(8'd47,  24'h00ff00);
    queue_write(8'd48,  24'h123456);
    queue_write(8'd51,  24'hfedcba);
    queue_write(8'd128, 24'hff0000);
    queue_write(8'd1,   24'h0000ff);
    queue_write(8'd127, 24'h1e1e1e);
    queue_write(8'd200, 24'h0f0f0f);
    queue_write(8'd3,   24'h808080);
    queue_write(8'd250, 24'h7f7f7f);
    queue_write(8'd170, 24'haaaaaa);
    queue_write(8'd85,  24'h555555);
    queue_write(8'd249, 24'h3c3c3c);
    queue_random(400);
    wait_drained();

    set_mode(1'b1, 1'b1);
    queue_random(400);
    wait_drained();

    // hold both streams busy for a whole phase
    set_mode(1'b1, 1'b0);
    stalls_on = 1'b0;
    queue_random(400);
    wait_drained();
    stalls_on = 1'b1;

    set_mode(1'b0, 1'b1);
    queue_random(400);
    wait_drained();

    set_mode(1'b0, 1'b0);
    queue_random(300);
    wait_drained();

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
